// ===== hw/rtl/cclex_pkg.sv =====
// Shared types, constants and character-class functions of the comment-stripping lexer.
`default_nettype none

package cclex_pkg;

  localparam int unsigned LineBits    = 16;
  localparam int unsigned LineOutBits = 16;

  localparam int unsigned MidDepth   = 4;
  localparam int unsigned MidPtrBits = $clog2(MidDepth);
  localparam int unsigned MidCntBits = $clog2(MidDepth + 1);

  // The result queue depth must be a power of two.
  localparam int unsigned ResDepth   = 8;
  localparam int unsigned ResPtrBits = $clog2(ResDepth);
  localparam int unsigned ResCntBits = $clog2(ResDepth + 1);
  localparam int unsigned MaxRes     = 4;
  localparam int unsigned NumCand    = 5;

  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharBar   = 8'h7C;

  typedef enum logic [2:0] {
    KIND_NONE = 3'b001,
    KIND_WORD = 3'b010,
    KIND_PAIR = 3'b100
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_slash;
    logic       has_c;
    logic       flush;
  } mid_entry_t;

  typedef struct packed {
    logic [7:0]             ch;
    logic                   last;
    logic [LineOutBits-1:0] line;
  } res_t;

  typedef struct packed {
    logic [1:0]      ev;
    logic [1:0][7:0] ec;
    logic [1:0]      el;
    logic [7:0]      held;
    kind_e           kind;
    logic            lf;
  } lex_out_t;

  function automatic logic is_word(logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F, 8'h23});
  endfunction

  function automatic logic is_prefix(logic [7:0] c);
    return (c inside {CharEq, CharBang, CharLt, CharGt, CharAmp, CharBar});
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return (c inside {8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3B, 8'h2C, 8'h2B, CharStar,
                      CharSlash, CharEq, CharLt, CharGt, 8'h2D});
  endfunction

  function automatic logic forms_pair(logic [7:0] p, logic [7:0] c);
    logic r;
    if (c == CharEq) begin
      r = (p inside {CharEq, CharBang, CharLt, CharGt});
    end else begin
      r = ((p == CharAmp) && (c == CharAmp)) || ((p == CharBar) && (c == CharBar));
    end
    return r;
  endfunction

  // One lexer step: slot 0 carries the held character, slot 1 the new one.
  function automatic lex_out_t lex_char(logic [7:0] held, kind_e kind, logic [7:0] c);
    lex_out_t o;
    logic     go;
    o.ev   = 2'b00;
    o.ec   = {c, held};
    o.el   = 2'b00;
    o.held = held;
    o.kind = kind;
    o.lf   = 1'b0;
    go     = 1'b1;
    case (kind)
      KIND_WORD: begin
        o.ev[0] = 1'b1;
        if (is_word(c)) begin
          o.held = c;
          go     = 1'b0;
        end else begin
          o.el[0] = 1'b1;
          o.kind  = KIND_NONE;
        end
      end
      KIND_PAIR: begin
        if (forms_pair(held, c)) begin
          o.ev   = 2'b11;
          o.el   = 2'b10;
          o.kind = KIND_NONE;
          go     = 1'b0;
        end else begin
          o.ev[0] = is_single(held);
          o.el[0] = 1'b1;
          o.kind  = KIND_NONE;
        end
      end
      default: begin
      end
    endcase
    if (go) begin
      if (is_word(c)) begin
        o.held = c;
        o.kind = KIND_WORD;
      end else if (is_prefix(c)) begin
        o.held = c;
        o.kind = KIND_PAIR;
      end else if (is_single(c)) begin
        o.ev[1] = 1'b1;
        o.el[1] = 1'b1;
      end else if (c == CharLf) begin
        o.lf = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic logic [LineOutBits-1:0] line_out(logic [LineBits-1:0] cnt);
    logic [31:0] w;
    w = 32'(cnt);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cclex_front.sv =====
// Front end: strips line and block comments and classifies each byte into a lexer entry.
`default_nettype none

module cclex_front
  import cclex_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] text_char_i,
  input  wire logic       text_last_i,
  output mid_entry_t      entry_o,
  output logic            entry_valid_o
);

  logic pend_q, pend_d;
  logic in_line_q, in_line_d;
  logic in_block_q, in_block_d;
  logic star_q, star_d;

  always_comb begin
    logic [7:0] c;
    logic       has_slash;
    logic       has_c;
    c          = text_char_i;
    has_slash  = 1'b0;
    has_c      = 1'b0;
    pend_d     = pend_q;
    in_line_d  = in_line_q;
    in_block_d = in_block_q;
    star_d     = star_q;
    if (in_line_q) begin
      if ((c == CharCr) || (c == CharLf)) begin
        in_line_d = 1'b0;
        if (in_block_q) begin
          star_d = 1'b0;
        end else begin
          has_c = 1'b1;
        end
      end
    end else if (pend_q) begin
      pend_d = 1'b0;
      if (c == CharSlash) begin
        in_line_d = 1'b1;
      end else if (in_block_q) begin
        if (star_q) begin
          in_block_d = 1'b0;
          star_d     = 1'b0;
          has_c      = 1'b1;
        end else begin
          star_d = (c == CharStar);
        end
      end else if (c == CharStar) begin
        in_block_d = 1'b1;
        star_d     = 1'b0;
      end else begin
        has_slash = 1'b1;
        has_c     = 1'b1;
      end
    end else if (c == CharSlash) begin
      pend_d = 1'b1;
    end else if (in_block_q) begin
      star_d = (c == CharStar);
    end else begin
      has_c = 1'b1;
    end

    if (text_last_i) begin
      if (pend_d && !in_line_d && !in_block_d) begin
        has_slash = 1'b1;
      end
      pend_d     = 1'b0;
      in_line_d  = 1'b0;
      in_block_d = 1'b0;
      star_d     = 1'b0;
    end

    entry_o.ch        = c;
    entry_o.has_slash = has_slash;
    entry_o.has_c     = has_c;
    entry_o.flush     = text_last_i;
    entry_valid_o     = take_i && (has_slash || has_c || text_last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      in_line_q  <= 1'b0;
      in_block_q <= 1'b0;
      star_q     <= 1'b0;
    end else if (take_i) begin
      pend_q     <= pend_d;
      in_line_q  <= in_line_d;
      in_block_q <= in_block_d;
      star_q     <= star_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cclex_midq.sv =====
// Short queue of lexer entries between the front end and the lexer.
`default_nettype none

module cclex_midq
  import cclex_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire mid_entry_t entry_i,
  output logic      full_o,
  input  wire logic pop_i,
  output mid_entry_t entry_o,
  output logic      valid_o
);

  mid_entry_t            mem_q [MidDepth];
  logic [MidPtrBits-1:0] wr_q, rd_q;
  logic [MidCntBits-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == MidCntBits'(MidDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == MidPtrBits'(MidDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == MidPtrBits'(MidDepth - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cclex_back.sv =====
// Back end: token lexer, line counter and the result queue.
`default_nettype none

module cclex_back
  import cclex_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              entry_valid_i,
  input  wire mid_entry_t        entry_i,
  output logic                   entry_take_o,
  input  wire logic              pop,
  output logic                   empty,
  output logic [7:0]             token_char_o,
  output logic                   token_last_o,
  output logic [LineOutBits-1:0] line_number_o
);

  logic [7:0]            held_q, held_d;
  kind_e                 kind_q, kind_d;
  logic [LineBits-1:0]   line_q, line_d;

  res_t                  res_mem_q [ResDepth];
  logic [ResPtrBits-1:0] wr_q, rd_q;
  logic [ResCntBits-1:0] cnt_q;
  logic [ResCntBits-1:0] n_push;

  logic [NumCand-1:0]    cv;
  logic [7:0]            cc [NumCand];
  logic [NumCand-1:0]    cl;
  logic [ResPtrBits-1:0] slot [NumCand];
  logic [LineOutBits-1:0] line_now;
  logic                  take, do_pop;

  assign take         = entry_valid_i && (cnt_q <= ResCntBits'(ResDepth - MaxRes));
  assign entry_take_o = take;
  assign empty        = (cnt_q == '0);
  assign do_pop       = pop && !empty;
  assign line_now     = line_out(line_q);

  assign token_char_o  = res_mem_q[rd_q].ch;
  assign token_last_o  = res_mem_q[rd_q].last;
  assign line_number_o = res_mem_q[rd_q].line;

  always_comb begin
    lex_out_t              la, lb;
    kind_e                 k1, k2;
    logic [7:0]            h1, h2;
    logic [ResPtrBits-1:0] ofs;
    la = lex_char(held_q, kind_q, CharSlash);
    k1 = entry_i.has_slash ? la.kind : kind_q;
    h1 = entry_i.has_slash ? la.held : held_q;
    lb = lex_char(h1, k1, entry_i.ch);
    k2 = entry_i.has_c ? lb.kind : k1;
    h2 = entry_i.has_c ? lb.held : h1;

    cv[0] = entry_i.has_slash && la.ev[0];
    cc[0] = la.ec[0];
    cl[0] = la.el[0];
    cv[1] = entry_i.has_slash && la.ev[1];
    cc[1] = la.ec[1];
    cl[1] = la.el[1];
    cv[2] = entry_i.has_c && lb.ev[0];
    cc[2] = lb.ec[0];
    cl[2] = lb.el[0];
    cv[3] = entry_i.has_c && lb.ev[1];
    cc[3] = lb.ec[1];
    cl[3] = lb.el[1];
    cv[4] = entry_i.flush &&
            ((k2 == KIND_WORD) || ((k2 == KIND_PAIR) && is_single(h2)));
    cc[4] = h2;
    cl[4] = 1'b1;

    ofs    = '0;
    n_push = '0;
    for (int i = 0; i < NumCand; i++) begin
      slot[i] = wr_q + ofs;
      if (cv[i]) begin
        ofs    = ofs + 1'b1;
        n_push = n_push + 1'b1;
      end
    end

    held_d = h2;
    kind_d = entry_i.flush ? KIND_NONE : k2;
    line_d = line_q;
    if (entry_i.flush) begin
      line_d = LineBits'(1);
    end else if (entry_i.has_c && lb.lf && (line_q != '1)) begin
      line_d = line_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      held_q <= held_d;
      for (int i = 0; i < NumCand; i++) begin
        if (cv[i]) begin
          res_mem_q[slot[i]] <= '{ch: cc[i], last: cl[i], line: line_now};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_NONE;
      line_q <= LineBits'(1);
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (take) begin
        kind_q <= kind_d;
        line_q <= line_d;
        wr_q   <= wr_q + ResPtrBits'(n_push);
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (take ? n_push : '0) - ResCntBits'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/c_comment_strip_lexer.sv =====
// Top level of the C comment stripper and lexer.
//
//   Channel   Direction  Handshake       Payload
//   text      in         push / full     text_char_i, text_last_i
//   token     out        empty / pop     token_char_o, token_last_o, line_number_o
//
// One text byte is accepted per cycle while the entry queue has room.
// The results of an accepted byte pass through the entry queue and then the result queue before they can be taken.
// The lexer takes one queued entry per cycle when the result queue has four free places;
// results leave at one per cycle, so bytes that yield several results hold up the lexer.
// Reset is asynchronous, clears both queues and the comment flags, and sets the line count to one.
`default_nettype none

module c_comment_strip_lexer
  import cclex_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             text_char_i,
  input  wire logic                   text_last_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [7:0]                  token_char_o,
  output logic                        token_last_o,
  output logic [LineOutBits-1:0]      line_number_o
);

  mid_entry_t front_entry, mid_entry;
  logic       front_valid, mid_valid, mid_take, accept;

  assign accept = push && !full;

  cclex_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (accept),
    .text_char_i   (text_char_i),
    .text_last_i   (text_last_i),
    .entry_o       (front_entry),
    .entry_valid_o (front_valid)
  );

  cclex_midq u_midq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (mid_take),
    .entry_o (mid_entry),
    .valid_o (mid_valid)
  );

  cclex_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (mid_valid),
    .entry_i       (mid_entry),
    .entry_take_o  (mid_take),
    .pop           (pop),
    .empty         (empty),
    .token_char_o  (token_char_o),
    .token_last_o  (token_last_o),
    .line_number_o (line_number_o)
  );

endmodule

`default_nettype wire

// ===== test/c_comment_strip_lexer_tb.sv =====
// Self-checking testbench for the comment-stripping C lexer, with its own token predictor.
module c_comment_strip_lexer_tb;
  import cclex_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int StallLimit  = 4000;
  localparam int HoldCycles  = 60;
  localparam int PhaseBytes  = 55;
  localparam int DrainCycles = 20;
  localparam int MaxPrinted  = 50;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain_first;
  } text_item_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   push          = 1'b0;
  logic                   full;
  logic [7:0]             text_char_i   = '0;
  logic                   text_last_i   = 1'b0;
  logic                   empty;
  logic                   pop           = 1'b0;
  logic [7:0]             token_char_o;
  logic                   token_last_o;
  logic [LineOutBits-1:0] line_number_o;

  text_item_t text_queue[$];
  res_t       expected_tokens[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int recv_hold_gen  = 0;
  int recv_hold_seen = 0;
  int recv_hold_left = 0;
  int mismatches     = 0;
  int bytes_queued   = 0;
  int texts_queued   = 0;
  int tokens_checked = 0;
  int tokens_due     = 0;
  int tokens_seen    = 0;
  int full_stalls    = 0;
  int idle_run       = 0;

  string      word_set   = "abcxyzAZ_#0919QmT";
  string      pair_set   = "==!=<=>=&&||";
  string      single_set = "{}();,+*/=<>-";
  string      lone_set   = "!&|";
  logic [7:0] space_set[4] = '{CharSpace, CharTab, CharCr, CharLf};

  logic                cut_slash;
  logic                in_line_cmt;
  logic                blk_slash;
  logic                in_blk_cmt;
  logic                blk_star;
  logic [7:0]          held_ch;
  kind_e               held_k;
  logic [LineBits-1:0] line_cnt;
  int                  step_emits;

  c_comment_strip_lexer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .text_char_i  (text_char_i),
    .text_last_i  (text_last_i),
    .empty        (empty),
    .pop          (pop),
    .token_char_o (token_char_o),
    .token_last_o (token_last_o),
    .line_number_o(line_number_o)
  );

  function automatic bit word_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "_" || c == "#";
  endfunction

  function automatic bit opener_ch(logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|";
  endfunction

  function automatic bit single_ch(logic [7:0] c);
    return c == "{" || c == "}" || c == "(" || c == ")" || c == ";" || c == "," ||
           c == "+" || c == "*" || c == "/" || c == "=" || c == "<" || c == ">" || c == "-";
  endfunction

  function automatic bit pairs_with(logic [7:0] p, logic [7:0] c);
    if (c == "=") begin
      return p == "=" || p == "!" || p == "<" || p == ">";
    end
    return (p == "&" && c == "&") || (p == "|" && c == "|");
  endfunction

  function automatic void strip_reset();
    cut_slash   = 1'b0;
    in_line_cmt = 1'b0;
    blk_slash   = 1'b0;
    in_blk_cmt  = 1'b0;
    blk_star    = 1'b0;
    held_ch     = '0;
    held_k      = KIND_NONE;
    line_cnt    = LineBits'(1);
  endfunction

  function automatic void expect_token(logic [7:0] ch, logic last);
    res_t tok;
    if (step_emits < MaxRes) begin
      tok.ch   = ch;
      tok.last = last;
      tok.line = (64'(line_cnt) > 64'hFFFF) ? '1 : LineOutBits'(line_cnt);
      expected_tokens.push_back(tok);
      step_emits++;
      tokens_due++;
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    if (held_k == KIND_WORD) begin
      if (word_ch(c)) begin
        expect_token(held_ch, 1'b0);
        held_ch = c;
        return;
      end
      expect_token(held_ch, 1'b1);
      held_k = KIND_NONE;
    end else if (held_k == KIND_PAIR) begin
      if (pairs_with(held_ch, c)) begin
        expect_token(held_ch, 1'b0);
        expect_token(c, 1'b1);
        held_k = KIND_NONE;
        return;
      end
      if (single_ch(held_ch)) expect_token(held_ch, 1'b1);
      held_k = KIND_NONE;
    end
    if (word_ch(c)) begin
      held_ch = c;
      held_k  = KIND_WORD;
    end else if (opener_ch(c)) begin
      held_ch = c;
      held_k  = KIND_PAIR;
    end else if (single_ch(c)) begin
      expect_token(c, 1'b1);
    end else if (c == CharLf && line_cnt != '1) begin
      line_cnt = line_cnt + 1'b1;
    end
  endfunction

  function automatic void block_strip(logic [7:0] c);
    if (in_blk_cmt) begin
      if (blk_star && c == CharSlash) begin
        in_blk_cmt = 1'b0;
        blk_star   = 1'b0;
      end else begin
        blk_star = (c == CharStar);
      end
    end else if (blk_slash) begin
      if (c == CharStar) begin
        blk_slash  = 1'b0;
        in_blk_cmt = 1'b1;
        blk_star   = 1'b0;
      end else begin
        lex_byte(CharSlash);
        if (c != CharSlash) begin
          blk_slash = 1'b0;
          lex_byte(c);
        end
      end
    end else if (c == CharSlash) begin
      blk_slash = 1'b1;
    end else begin
      lex_byte(c);
    end
  endfunction

  function automatic void line_strip(logic [7:0] c);
    if (in_line_cmt) begin
      if (c == CharCr || c == CharLf) begin
        in_line_cmt = 1'b0;
        block_strip(c);
      end
    end else if (cut_slash) begin
      cut_slash = 1'b0;
      if (c == CharSlash) begin
        in_line_cmt = 1'b1;
      end else begin
        block_strip(CharSlash);
        block_strip(c);
      end
    end else if (c == CharSlash) begin
      cut_slash = 1'b1;
    end else begin
      block_strip(c);
    end
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic last);
    step_emits = 0;
    line_strip(c);
    if (last) begin
      if (cut_slash && !in_line_cmt) begin
        cut_slash = 1'b0;
        block_strip(CharSlash);
      end
      if (blk_slash && !in_blk_cmt) lex_byte(CharSlash);
      if (held_k == KIND_WORD || (held_k == KIND_PAIR && single_ch(held_ch))) begin
        expect_token(held_ch, 1'b1);
      end
      strip_reset();
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MaxPrinted) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_byte(logic [7:0] ch, logic last, bit drain = 1'b0);
    text_item_t it;
    it.ch          = ch;
    it.last        = last;
    it.drain_first = drain;
    text_queue.push_back(it);
    bytes_queued++;
    if (last) texts_queued++;
  endtask

  task automatic add_str(string s, logic ends);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], ends && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] comment_byte(bit in_block);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (in_block && $urandom_range(1) == 1) b = ($urandom_range(1) == 1) ? CharStar : CharSlash;
    if (!in_block && (b == CharLf || b == CharCr)) b = "x";
    return b;
  endfunction

  task automatic gen_text(bit drain);
    logic [7:0] txt[$];
    int         target;
    int         k;
    target = $urandom_range(30, 8);
    while (txt.size() < target) begin
      case ($urandom_range(9))
        0, 1: begin
          repeat ($urandom_range(4, 1)) txt.push_back(word_set[$urandom_range(word_set.len() - 1)]);
        end
        2: begin
          k = 2 * $urandom_range(5);
          txt.push_back(pair_set[k]);
          txt.push_back(pair_set[k + 1]);
        end
        3: txt.push_back(single_set[$urandom_range(single_set.len() - 1)]);
        4: txt.push_back(space_set[$urandom_range(3)]);
        5: begin
          txt.push_back(CharSlash);
          txt.push_back(CharSlash);
          repeat ($urandom_range(5)) txt.push_back(comment_byte(1'b0));
          txt.push_back(($urandom_range(1) == 1) ? CharLf : CharCr);
        end
        6: begin
          txt.push_back(CharSlash);
          txt.push_back(CharStar);
          repeat ($urandom_range(5)) txt.push_back(comment_byte(1'b1));
          txt.push_back(CharStar);
          txt.push_back(CharSlash);
        end
        7: txt.push_back(8'($urandom_range(255)));
        8: txt.push_back(lone_set[$urandom_range(2)]);
        default: txt.push_back(CharSpace);
      endcase
    end
    case ($urandom_range(11))
      0: begin
        txt.push_back(CharSlash);
        txt.push_back(CharStar);
        txt.push_back(comment_byte(1'b1));
      end
      1: txt.push_back(CharSlash);
      2: begin
        txt.push_back(CharSlash);
        txt.push_back(CharSlash);
        txt.push_back(comment_byte(1'b0));
      end
      default: begin
      end
    endcase
    for (int i = 0; i < txt.size(); i++) begin
      add_byte(txt[i], i == txt.size() - 1, drain && i == 0);
    end
  endtask

  task automatic fill_random();
    int start_bytes;
    start_bytes = bytes_queued;
    while (bytes_queued - start_bytes < PhaseBytes) gen_text($urandom_range(9) == 0);
  endtask

  task automatic drain_all();
    do @(negedge clk_i); while (text_queue.size() != 0 || push || expected_tokens.size() != 0);
  endtask

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    text_item_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
      strip_reset();
    end else begin
      if (push && !full) predict_tokens(text_char_i, text_last_i);
      if (push && full) full_stalls++;
      if (pop && !empty) tokens_seen++;
      if (!push || !full) begin
        if (text_queue.size() != 0 && !(text_queue[0].drain_first && tokens_due != tokens_seen) &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = text_queue.pop_front();
          push        <= 1'b1;
          text_char_i <= nxt.ch;
          text_last_i <= nxt.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        tokens_checked++;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("token char %h arrived with nothing expected", token_char_o));
        end else begin
          want = expected_tokens.pop_front();
          if (token_char_o !== want.ch) begin
            report_mismatch($sformatf("token_char %h, expected %h", token_char_o, want.ch));
          end
          if (token_last_o !== want.last) begin
            report_mismatch($sformatf("token_last %b on char %h, expected %b",
                                      token_last_o, want.ch, want.last));
          end
          if (line_number_o !== want.line) begin
            report_mismatch($sformatf("line_number %0d on char %h, expected %0d",
                                      line_number_o, want.ch, want.line));
          end
        end
      end
      if (recv_hold_gen != recv_hold_seen) begin
        recv_hold_seen = recv_hold_gen;
        recv_hold_left = HoldCycles;
      end
      if (recv_hold_left > 0) begin
        recv_hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_run <= 0;
    end else if (idle_run >= StallLimit) begin
      $display("Watchdog: nothing moved for %0d cycles.", StallLimit);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    wait (rst_ni);
    @(negedge clk_i);
    recv_hold_gen = 1;
    add_str("==!=<=>=&&||{}();,+*/-=", 1'b0);
    add_byte(CharTab, 1'b0);
    add_str("<", 1'b0);
    add_byte(8'h00, 1'b0);
    add_str(">", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_str("!&|", 1'b1);
    add_str("w//x", 1'b0);
    add_byte(CharCr, 1'b0);
    add_str("y/*/z*/", 1'b0);
    add_byte(CharLf, 1'b0);
    add_str("#_9", 1'b1);
    add_str("v/", 1'b1);
    add_str("/*u", 1'b1);
    gen_text(1'b1);
    fill_random();
    drain_all();

    send_idle_pct = 71;
    fill_random();
    drain_all();

    send_idle_pct  = 0;
    recv_stall_pct = 71;
    fill_random();
    drain_all();

    send_idle_pct  = 15;
    recv_stall_pct = 15;
    fill_random();
    drain_all();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d text bytes in %0d texts over directed cases and four pacing phases.",
             bytes_queued, texts_queued);
    $display("Checked %0d token characters; full held the input back on %0d cycles.",
             tokens_checked, full_stalls);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
